/* rtl/i2a_pkg.sv */
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Shared widths, format mode codes, character codes and the control structs
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package i2a_pkg;

    // Width of the integer that is formatted, read as two's complement.
    localparam int VALUE_WIDTH = 64;

    // Decimal digits that hold any VALUE_WIDTH-bit magnitude (log10(2) ~ 0.30103).
    localparam int BCD_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int SH_W       = 4 * BCD_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

    localparam int SHORT_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int FOUR_DIGITS = 4;

    localparam logic [VALUE_WIDTH-1:0] VALUE_SIGN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] VALUE_MAX  = ~VALUE_SIGN;

    // Format modes.
    localparam logic [2:0] OP_DEC       = 3'd0;
    localparam logic [2:0] OP_BIN       = 3'd1;
    localparam logic [2:0] OP_HEX       = 3'd2;
    localparam logic [2:0] OP_BYTE_BIN  = 3'd3;
    localparam logic [2:0] OP_FOUR_DEC  = 3'd4;
    localparam logic [2:0] OP_TRIM_BYTE = 3'd5;

    // Character codes.
    localparam logic [6:0] CH_ZERO           = 7'd48;
    localparam logic [6:0] CH_MINUS          = 7'd45;
    localparam logic [6:0] HEX_LETTER_OFFSET = 7'd55;
    localparam logic [3:0] DEC_LIMIT         = 4'd10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new item
        logic conv;      // one double-dabble step
        logic align;     // move the four-digit result to the top
        logic shift;     // drop the top digit
        logic sel_sign;  // present the minus sign
    } i2a_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_last;  // final conversion step is under way
        logic lead_zero;  // top digit is a leading zero that may be dropped
        logic neg;        // a minus sign is owed
        logic dig_last;   // top digit is the final one
    } i2a_status_t;

    function automatic logic [6:0] digit_ascii(input logic [3:0] d);
        logic [6:0] code;
        if (d < DEC_LIMIT) begin
            code = CH_ZERO + 7'(d);
        end else begin
            code = HEX_LETTER_OFFSET + 7'(d);
        end
        return code;
    endfunction

endpackage

/* rtl/i2a_datapath.sv */
// ----------------------------------------------------------------------------
// Integer to ASCII formatter datapath
// Holds the magnitude, the shared BCD / digit shift register and the digit
// counters, and forms the outgoing character.
// ----------------------------------------------------------------------------
module i2a_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [63:0]          s_value,
    input  logic [2:0]           s_operation,
    input  i2a_pkg::i2a_cmd_t    cmd,
    output i2a_pkg::i2a_status_t status,
    output logic [6:0]           m_character,
    output logic                 m_last
);

    localparam int W = i2a_pkg::VALUE_WIDTH;
    localparam int S = i2a_pkg::SH_W;
    localparam int C = i2a_pkg::CNT_W;

    logic [W-1:0] bin_reg, bin_next;
    logic [S-1:0] sh_reg, sh_next;
    logic [C-1:0] step_reg, step_next;
    logic [C-1:0] dig_reg, dig_next;
    logic         neg_reg, neg_next;
    logic         bit_reg, bit_next;
    logic         sup_reg, sup_next;
    logic         four_reg, four_next;

    logic [W-1:0] v;
    logic [W-1:0] mag_raw;
    logic [W-1:0] mag;
    logic [S-1:0] adj;
    logic [3:0]   digit;

    // Two's complement magnitude, saturated so the most negative value
    // prints as the next one up.
    always_comb begin
        v       = s_value[W-1:0];
        mag_raw = v[W-1] ? (~v + W'(1)) : v;
        mag     = (mag_raw == i2a_pkg::VALUE_SIGN) ? i2a_pkg::VALUE_MAX : mag_raw;
    end

    // Add three to every BCD digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < i2a_pkg::BCD_DIGITS; i++) begin
            adj[4*i +: 4] = (sh_reg[4*i +: 4] >= 4'd5) ? sh_reg[4*i +: 4] + 4'd3
                                                       : sh_reg[4*i +: 4];
        end
    end

    always_comb begin
        bin_next  = bin_reg;
        sh_next   = sh_reg;
        step_next = step_reg;
        dig_next  = dig_reg;
        neg_next  = neg_reg;
        bit_next  = bit_reg;
        sup_next  = sup_reg;
        four_next = four_reg;
        if (cmd.load) begin
            bin_next  = mag;
            sh_next   = '0;
            step_next = C'(W);
            neg_next  = v[W-1];
            bit_next  = 1'b0;
            sup_next  = 1'b1;
            four_next = 1'b0;
            dig_next  = C'(i2a_pkg::BCD_DIGITS);
            case (s_operation)
                i2a_pkg::OP_DEC: begin
                end
                i2a_pkg::OP_BIN: begin
                    sh_next  = S'(mag) << (S - W);
                    bit_next = 1'b1;
                    dig_next = C'(W);
                end
                i2a_pkg::OP_HEX: begin
                    sh_next  = S'(mag) << (S - 4 * i2a_pkg::HEX_DIGITS);
                    dig_next = C'(i2a_pkg::HEX_DIGITS);
                end
                i2a_pkg::OP_BYTE_BIN: begin
                    sh_next  = S'(v[i2a_pkg::BYTE_W-1:0]) << (S - i2a_pkg::BYTE_W);
                    neg_next = 1'b0;
                    bit_next = 1'b1;
                    sup_next = 1'b0;
                    dig_next = C'(i2a_pkg::BYTE_W);
                end
                i2a_pkg::OP_FOUR_DEC: begin
                    bin_next  = W'(v[i2a_pkg::SHORT_W-1:0]) << (W - i2a_pkg::SHORT_W);
                    step_next = C'(i2a_pkg::SHORT_W);
                    neg_next  = 1'b0;
                    sup_next  = 1'b0;
                    four_next = 1'b1;
                    dig_next  = C'(i2a_pkg::FOUR_DIGITS);
                end
                i2a_pkg::OP_TRIM_BYTE: begin
                    sh_next  = S'(v[i2a_pkg::BYTE_W-1:0]) << (S - i2a_pkg::BYTE_W);
                    neg_next = 1'b0;
                    bit_next = 1'b1;
                    dig_next = C'(i2a_pkg::BYTE_W);
                end
                default: begin
                    neg_next = 1'b0;
                end
            endcase
        end else if (cmd.conv) begin
            sh_next   = {adj[S-2:0], bin_reg[W-1]};
            bin_next  = bin_reg << 1;
            step_next = step_reg - C'(1);
        end else if (cmd.align) begin
            // Only the low four BCD digits count: that is the value mod 10000.
            if (four_reg) begin
                sh_next = sh_reg << (S - 4 * i2a_pkg::FOUR_DIGITS);
            end
        end else if (cmd.shift) begin
            sh_next  = bit_reg ? (sh_reg << 1) : (sh_reg << 4);
            dig_next = dig_reg - C'(1);
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg  <= bin_next;
        sh_reg   <= sh_next;
        step_reg <= step_next;
        dig_reg  <= dig_next;
        bit_reg  <= bit_next;
        sup_reg  <= sup_next;
        four_reg <= four_next;
        if (!aresetn) begin
            neg_reg <= 1'b0;
        end else begin
            neg_reg <= neg_next;
        end
    end

    assign digit = bit_reg ? {3'b000, sh_reg[S-1]} : sh_reg[S-1 -: 4];

    assign status.conv_last = (step_reg == C'(1));
    assign status.dig_last  = (dig_reg == C'(1));
    assign status.lead_zero = sup_reg && (digit == 4'd0) && (dig_reg != C'(1));
    assign status.neg       = neg_reg;

    assign m_character = cmd.sel_sign ? i2a_pkg::CH_MINUS : i2a_pkg::digit_ascii(digit);
    assign m_last      = !cmd.sel_sign && status.dig_last;

endmodule

/* rtl/i2a_ctrl.sv */
// ----------------------------------------------------------------------------
// Integer to ASCII formatter controller
// Sequences capture, conversion, leading-zero skipping and character output.
// ----------------------------------------------------------------------------
module i2a_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_operation,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  i2a_pkg::i2a_status_t status,
    output i2a_pkg::i2a_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_ALIGN = 3'd2;
    localparam logic [2:0] ST_SKIP  = 3'd3;
    localparam logic [2:0] ST_SIGN  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    if (s_operation inside {i2a_pkg::OP_DEC, i2a_pkg::OP_FOUR_DEC}) begin
                        state_next = ST_CONV;
                    end else if (s_operation inside {i2a_pkg::OP_BIN, i2a_pkg::OP_HEX,
                                                     i2a_pkg::OP_BYTE_BIN,
                                                     i2a_pkg::OP_TRIM_BYTE}) begin
                        state_next = ST_SKIP;
                    end
                end
            end
            ST_CONV: begin
                cmd.conv = 1'b1;
                if (status.conv_last) begin
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                cmd.align  = 1'b1;
                state_next = ST_SKIP;
            end
            ST_SKIP: begin
                if (status.lead_zero) begin
                    cmd.shift = 1'b1;
                end else begin
                    state_next = status.neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                m_valid      = 1'b1;
                cmd.sel_sign = 1'b1;
                if (m_ready) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.shift = 1'b1;
                    if (status.dig_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/integer_to_ascii_formatter.sv */
// ----------------------------------------------------------------------------
// Integer to ASCII formatter
// Turns one two's-complement integer and a format mode into its ASCII
// characters, most significant first, with the final character marked.
// ----------------------------------------------------------------------------
// Usage: an item on the s_ channel carries s_value and s_operation. The
// block answers with one item per character on the m_ channel; m_last marks
// the final character of the item. Modes 6 and 7 are taken and dropped with
// no character at all.
// Sequence: the item is captured, then for the decimal modes one double-dabble
// step runs per value bit (all 64 for signed decimal, the low 16 for the
// four-digit mode), followed by an alignment step. Leading zeros are dropped at
// one digit per cycle, then the minus sign and the digits leave at one per
// cycle while m_ready is high. Each of the 20 digit places of a signed
// decimal item is either dropped or sent.
// Only one item is in the block at a time: s_ready is high only when the
// previous item's characters are all delivered.
// At reset the controller returns to idle and any item in progress is lost.
// When the receiver stalls, the current character holds on m_character and
// m_last and the block simply waits.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_value,
    input  logic [2:0]  s_operation,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_character,
    output logic        m_last
);

    i2a_pkg::i2a_cmd_t    cmd;
    i2a_pkg::i2a_status_t status;

    // The controller owns both handshakes and steps the datapath.
    i2a_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // The datapath holds the magnitude and the shared BCD / digit register.
    i2a_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .s_operation (s_operation),
        .cmd         (cmd),
        .status      (status),
        .m_character (m_character),
        .m_last      (m_last)
    );

    // The block never takes a new item while it still shows a character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a character is pending");

    // After the final character goes out, the block is idle again.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> (s_ready && !m_valid))
        else $error("block not idle after the final character");

    // A minus sign is always followed by at least one digit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_character == i2a_pkg::CH_MINUS)) |-> !m_last)
        else $error("minus sign marked as final character");

endmodule

/* tb/tb_integer_to_ascii_formatter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer to ASCII formatter testbench
// Sends integers in every format mode through the block and checks each
// character and its last flag against text worked out inside the bench.
// ----------------------------------------------------------------------------
class formatted_text_board;

    localparam logic [6:0] CH_ONE      = 7'd49;
    localparam logic [6:0] CH_LETTER_A = 7'd65;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } text_char_t;

    text_char_t pending_chars[$];
    int         mismatches = 0;
    int         chars_seen = 0;

    task report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // Builds the characters for one accepted item and queues them.
    function void note_item(input logic [63:0] value, input logic [2:0] op);
        logic [6:0]  text[$];
        logic [6:0]  digits[$];
        logic [63:0] mag;
        logic [63:0] base;
        logic [63:0] d;
        logic [15:0] four;
        text_char_t  c;
        base = 64'd0;
        mag  = 64'd0;
        case (op)
            i2a_pkg::OP_DEC, i2a_pkg::OP_BIN, i2a_pkg::OP_HEX: begin
                base = (op == i2a_pkg::OP_DEC) ? 64'd10 :
                       (op == i2a_pkg::OP_BIN) ? 64'd2 : 64'd16;
                mag  = value;
                if (value[i2a_pkg::VALUE_WIDTH-1]) begin
                    text.push_back(i2a_pkg::CH_MINUS);
                    mag = -value;
                    if (mag == i2a_pkg::VALUE_SIGN) begin
                        mag = i2a_pkg::VALUE_MAX;
                    end
                end
            end
            i2a_pkg::OP_TRIM_BYTE: begin
                base = 64'd2;
                mag  = {56'd0, value[7:0]};
            end
            i2a_pkg::OP_BYTE_BIN: begin
                for (int i = i2a_pkg::BYTE_W - 1; i >= 0; i--) begin
                    text.push_back(value[i] ? CH_ONE : i2a_pkg::CH_ZERO);
                end
            end
            i2a_pkg::OP_FOUR_DEC: begin
                four = value[15:0] % 16'd10000;
                text.push_back(i2a_pkg::CH_ZERO + 7'(four / 1000));
                text.push_back(i2a_pkg::CH_ZERO + 7'((four % 1000) / 100));
                text.push_back(i2a_pkg::CH_ZERO + 7'((four % 100) / 10));
                text.push_back(i2a_pkg::CH_ZERO + 7'(four % 10));
            end
            default: begin
            end
        endcase
        if (base != 64'd0) begin
            do begin
                d = mag % base;
                digits.push_front(d < 10 ? i2a_pkg::CH_ZERO + 7'(d)
                                         : CH_LETTER_A + 7'(d - 10));
                mag = mag / base;
            end while (mag != 64'd0);
            foreach (digits[i]) begin
                text.push_back(digits[i]);
            end
        end
        foreach (text[i]) begin
            c.code = text[i];
            c.last = (i == text.size() - 1);
            pending_chars.push_back(c);
        end
    endfunction

    task check_char(input logic [6:0] code, input logic last);
        text_char_t want;
        chars_seen++;
        if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("char %0d 0x%02h arrived with nothing pending",
                                      chars_seen, code));
        end else begin
            want = pending_chars.pop_front();
            if (code !== want.code) begin
                report_mismatch($sformatf("char %0d: code 0x%02h, wanted 0x%02h",
                                          chars_seen, code, want.code));
            end
            if (last !== want.last) begin
                report_mismatch($sformatf("char %0d: last %b, wanted %b",
                                          chars_seen, last, want.last));
            end
        end
    endtask

    function int pending();
        return pending_chars.size();
    endfunction

    task flush_leftovers();
        if (pending_chars.size() != 0) begin
            report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
        end
    endtask

endclass

module tb_integer_to_ascii_formatter;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_ITEMS = 270;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;

    // Codes that the block accepts and throws away.
    localparam logic [2:0] OP_UNUSED_LO = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    // How the receiver paces m_ready.
    typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_BURSTY} rx_style_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [63:0] s_value     = '0;
    logic [2:0]  s_operation = i2a_pkg::OP_DEC;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [6:0]  m_character;
    logic        m_last;

    // Sender and receiver pacing, steered by the main sequence.
    rx_style_t rx_style  = RX_STEADY;
    bit        gaps_on   = 1'b0;
    bit        hold_req  = 1'b0;
    int        burst_left = 0;

    logic [2:0] format_ops [6] = '{i2a_pkg::OP_DEC, i2a_pkg::OP_BIN, i2a_pkg::OP_HEX,
                                   i2a_pkg::OP_BYTE_BIN, i2a_pkg::OP_FOUR_DEC,
                                   i2a_pkg::OP_TRIM_BYTE};

    formatted_text_board board = new();

    integer_to_ascii_formatter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // The monitor samples both channels at the rising edge. All bench drivers
    // change their signals with nonblocking assignments at the same edge, so
    // the values seen here are always the ones from before the edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                board.note_item(s_value, s_operation);
            end
            if (m_valid && m_ready) begin
                board.check_char(m_character, m_last);
            end
        end
    end

    // Offers one item and returns at the edge where it is taken. The sender
    // works in bursts; at the end of a burst it may drop valid for a gap. The
    // gaps are mostly short, but now and then long enough for the block to
    // run dry so that a new item lands on an idle block as well as a busy one.
    task automatic send_item(input logic [63:0] value, input logic [2:0] op);
        int gap;
        s_valid     <= 1'b1;
        s_value     <= value;
        s_operation <= op;
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else if (gaps_on) begin
            burst_left = $urandom_range(0, 7);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 120)
                                              : $urandom_range(0, 5);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Integers of many sizes: full width, a random bit length of either
    // sign, and small numbers around the four-digit range.
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [63:0] mask;
        v    = {$urandom, $urandom};
        mask = (64'd1 << $urandom_range(1, 63)) - 64'd1;
        case ($urandom_range(0, 4))
            0, 1: begin
            end
            2: v = v & mask;
            3: v = -(v & mask);
            default: begin
                v = 64'($urandom_range(0, 20000));
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    // Receiver pacing. A pending hold request wins over the normal style
    // and keeps m_ready low for a long stretch counted here, while the
    // sender keeps offering items and the block backs up into s_ready.
    initial begin
        int run_left;
        int stall_left;
        run_left   = 0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                case (rx_style)
                    RX_STEADY: m_ready <= 1'b1;
                    RX_RANDOM: m_ready <= ($urandom_range(0, 2) != 0);
                    default: begin
                        if (run_left > 0) begin
                            run_left--;
                            m_ready <= 1'b1;
                        end else if (stall_left > 0) begin
                            stall_left--;
                            m_ready <= 1'b0;
                        end else begin
                            run_left   = $urandom_range(1, 8);
                            stall_left = $urandom_range(1, 6);
                            m_ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Main sequence: reset, directed corners with no idling on either side,
    // then four random phases of varied receiver pacing, sender gaps in the first two.
    initial begin
        int          counted;
        logic [63:0] v;
        logic [2:0]  op;
        counted = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero, the largest positive and negative values, and the most
        // negative value, which saturates, in each signed mode.
        for (int i = 0; i < 3; i++) begin
            send_item(64'd0, format_ops[i]);
            send_item(i2a_pkg::VALUE_MAX, format_ops[i]);
            send_item(-i2a_pkg::VALUE_MAX, format_ops[i]);
            send_item(i2a_pkg::VALUE_SIGN, format_ops[i]);
        end
        send_item(-64'd1, i2a_pkg::OP_HEX);
        send_item(64'hFFFF_FFFF_FFFF_FF00, i2a_pkg::OP_BYTE_BIN);
        send_item(64'h0123_4567_89AB_CDFF, i2a_pkg::OP_BYTE_BIN);
        send_item(64'h0000_0000_0000_FFFF, i2a_pkg::OP_FOUR_DEC);
        send_item(64'd10000, i2a_pkg::OP_FOUR_DEC);
        send_item(64'hFFFF_FFFF_FFFF_270F, i2a_pkg::OP_FOUR_DEC);
        // A byte of zero under nonzero upper bits still prints one zero.
        send_item(64'h8000_0000_0000_FF00, i2a_pkg::OP_TRIM_BYTE);
        send_item(64'd255, i2a_pkg::OP_TRIM_BYTE);
        send_item(64'd1, i2a_pkg::OP_TRIM_BYTE);
        // The two unused codes are taken and produce nothing.
        send_item(64'h7FFF_FFFF_FFFF_FFFF, OP_UNUSED_LO);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, OP_UNUSED_HI);

        // Random phases. The long receiver hold-off is requested at the
        // start of the first one.
        gaps_on  = 1'b1;
        rx_style = RX_RANDOM;
        hold_req = 1'b1;
        while (counted < RANDOM_ITEMS) begin
            if (counted == RANDOM_ITEMS / 3) begin
                rx_style = RX_BURSTY;
            end else if (counted == 2 * RANDOM_ITEMS / 3) begin
                gaps_on  = 1'b0;
                rx_style = RX_STEADY;
            end else if (counted == 5 * RANDOM_ITEMS / 6) begin
                rx_style = RX_RANDOM;
            end
            v = random_value();
            if ($urandom_range(0, 19) == 0) begin
                op = ($urandom_range(0, 1) == 0) ? OP_UNUSED_LO : OP_UNUSED_HI;
            end else begin
                op = format_ops[$urandom_range(0, 5)];
                counted++;
            end
            send_item(v, op);
        end
        s_valid <= 1'b0;

        // Let the last characters drain, then give the block some time to
        // show any stray output before deciding.
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        board.flush_leftovers();
        if (board.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: the slowest correct run is far below this mark.
    initial begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/i2a_pkg.sv
rtl/i2a_datapath.sv
rtl/i2a_ctrl.sv
rtl/integer_to_ascii_formatter.sv
tb/tb_integer_to_ascii_formatter.sv
